// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro takes a label, a clock, an active-low reset, a condition and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define SFC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfc assertion failed");

// The consequence must hold in the cycle after the condition.
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfc assertion failed");

`endif

// ===== design/sfc_pkg.sv =====
`timescale 1ns / 1ps

package sfc_pkg;

    // Shortest frame that is judged on its contents.
    localparam int MIN_FRAME_BYTES = 5;

    // The byte count stops at this value.
    localparam logic [2:0] COUNT_MAX = 3'd7;

    typedef enum logic [2:0] {
        VERDICT_UPDATE   = 3'd0,
        VERDICT_OTHER    = 3'd1,
        VERDICT_SHORT    = 3'd2,
        VERDICT_FORMAT   = 3'd3,
        VERDICT_ADDRESS  = 3'd4,
        VERDICT_CHECKSUM = 3'd5
    } t_verdict;

    typedef enum logic [1:0] {
        CFG_START_CODE   = 2'd0,
        CFG_END_CODE     = 2'd1,
        CFG_DATA_COMMAND = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] data_command;
    } t_cfg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
        logic [7:0] expected_address;
    } t_item;

    typedef struct packed {
        t_verdict   verdict;
        logic [7:0] sensor_address;
        logic [7:0] sensor_value;
        logic       flush_request;
    } t_result;

endpackage

// ===== design/sfc_if.sv =====
`timescale 1ns / 1ps

// Channel that carries received frame bytes.
interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;
    logic [7:0] expected_address;

    modport source (output valid, output rx_byte, output frame_end, output expected_address,
                    input ready);
    modport sink (input valid, input rx_byte, input frame_end, input expected_address,
                  output ready);
endinterface

// Channel that carries frame verdicts.
interface sfc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [7:0] sensor_address;
    logic [7:0] sensor_value;
    logic       flush_request;

    modport source (output valid, output verdict, output sensor_address,
                    output sensor_value, output flush_request, input ready);
    modport sink (input valid, input verdict, input sensor_address,
                  input sensor_value, input flush_request, output ready);
endinterface

// ===== design/sensor_frame_checker_unit.sv =====
`timescale 1ns / 1ps
// Sensor frame checker. Frame bytes enter on i_frame, one byte per transfer, with
// frame_end set on the last byte and expected_address valid on that byte. Verdicts
// leave on o_result, one transfer per frame, none for the other bytes.
// Three registers (start code, end code, data command) are written through the
// i_cfg_we / i_cfg_index / i_cfg_data port; the user writes them only while no
// frame byte is in flight, as the block itself does not enforce it. A verdict
// passes the input register and then the result register before it is offered.
// Throughput: one byte per cycle, save that a last byte waits for a free result
// register. The whole check is a few byte compares and an XOR between the input
// register and the result register, so nothing iterates.
// When the receiver stalls, the verdict holds in the result register; the input
// register keeps taking ordinary bytes, but a last byte waits in it with ready low
// until the result register frees.
// Reset (synchronous, active low) clears the registers, the frame state and both
// valid flags; i_frame.ready is high in the first cycle after reset.
module sensor_frame_checker_unit
    import sfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data,
    sfc_in_if.sink       i_frame,
    sfc_out_if.source    o_result
);

    // Configuration registers.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_START_CODE:   r_cfg.start_code   <= i_cfg_data;
                CFG_END_CODE:     r_cfg.end_code     <= i_cfg_data;
                CFG_DATA_COMMAND: r_cfg.data_command <= i_cfg_data;
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    // Input register. A byte that is not the last one always moves on, since it
    // produces no verdict; the last byte waits for a free result register.
    logic    r_in_valid;
    t_item   r_in;
    logic    out_free;
    logic    in_step;
    logic    in_ready;
    t_result verdict_next;

    assign out_free = !o_result.valid || o_result.ready;
    assign in_step  = r_in_valid && (!r_in.frame_end || out_free);
    assign in_ready = !r_in_valid || in_step;
    assign i_frame.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_frame.valid) begin
            r_in <= '{rx_byte: i_frame.rx_byte, frame_end: i_frame.frame_end,
                      expected_address: i_frame.expected_address};
        end
    end

    // Frame state and verdict logic.
    sfc_frame u_frame (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_step),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (verdict_next)
    );

    // Result register.
    logic    r_out_valid;
    t_result r_out;
    logic    out_load;

    assign out_load = in_step && r_in.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= verdict_next;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.verdict        = r_out.verdict;
    assign o_result.sensor_address = r_out.sensor_address;
    assign o_result.sensor_value   = r_out.sensor_value;
    assign o_result.flush_request  = r_out.flush_request;

endmodule

// ===== design/sfc_frame.sv =====
`timescale 1ns / 1ps

// Holds the state of the frame being received and judges it on its last byte.
module sfc_frame
    import sfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    logic [2:0] r_count;
    logic [7:0] r_first;
    logic [7:0] r_address;
    logic [7:0] r_command;
    logic [7:0] r_value;
    logic [7:0] r_previous;
    logic [7:0] r_xor;

    logic [2:0] n_count;
    logic [7:0] n_first;
    logic [7:0] n_address;
    logic [7:0] n_command;
    logic [7:0] n_value;
    logic [7:0] n_previous;
    logic [7:0] n_xor;

    logic [3:0] total;

    always_comb begin
        n_first    = (r_count == 3'd0) ? i_item.rx_byte : r_first;
        n_address  = (r_count == 3'd1) ? i_item.rx_byte : r_address;
        n_command  = (r_count == 3'd2) ? i_item.rx_byte : r_command;
        n_value    = (r_count == 3'd3) ? i_item.rx_byte : r_value;
        n_previous = i_item.rx_byte;
        n_xor      = (r_count != 3'd0) ? (r_xor ^ r_previous) : r_xor;
        n_count    = (r_count != COUNT_MAX) ? (r_count + 3'd1) : r_count;
    end

    // The verdict looks at the stored bytes with the current byte merged in.
    always_comb begin
        total    = {1'b0, r_count} + 4'd1;
        o_result = '{verdict: VERDICT_OTHER, sensor_address: 8'd0, sensor_value: 8'd0,
                     flush_request: 1'b0};
        if (total < 4'(MIN_FRAME_BYTES)) begin
            o_result.verdict = VERDICT_SHORT;
        end else if (n_first != i_cfg.start_code || i_item.rx_byte != i_cfg.end_code) begin
            o_result.verdict       = VERDICT_FORMAT;
            o_result.flush_request = 1'b1;
        end else if (n_address != i_item.expected_address) begin
            o_result.verdict       = VERDICT_ADDRESS;
            o_result.flush_request = 1'b1;
        end else if (r_previous != r_xor) begin
            o_result.verdict = VERDICT_CHECKSUM;
        end else if (n_command == i_cfg.data_command) begin
            o_result.verdict        = VERDICT_UPDATE;
            o_result.sensor_address = n_address;
            o_result.sensor_value   = n_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.frame_end)) begin
            r_count    <= 3'd0;
            r_first    <= 8'd0;
            r_address  <= 8'd0;
            r_command  <= 8'd0;
            r_value    <= 8'd0;
            r_previous <= 8'd0;
            r_xor      <= 8'd0;
        end else if (i_step) begin
            r_count    <= n_count;
            r_first    <= n_first;
            r_address  <= n_address;
            r_command  <= n_command;
            r_value    <= n_value;
            r_previous <= n_previous;
            r_xor      <= n_xor;
        end
    end

endmodule

// ===== design/sfc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Watches the result channel of the frame checker.
module sfc_checker
    import sfc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_verdict,
    input logic [7:0] i_sensor_address,
    input logic [7:0] i_sensor_value,
    input logic       i_flush_request
);

    // A stalled verdict stays offered and unchanged.
    `SFC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_verdict) && $stable(i_sensor_address) && $stable(i_sensor_value) && $stable(i_flush_request))

    // Flush is raised for format and address faults and for nothing else.
    `SFC_ASSERT_SAME(a_flush_match, i_clk, i_rst_n, i_out_valid, i_flush_request == (i_verdict == VERDICT_FORMAT || i_verdict == VERDICT_ADDRESS))

    // Address and value are only carried with a data update.
    `SFC_ASSERT_SAME(a_fields_zero, i_clk, i_rst_n, i_out_valid && i_verdict != VERDICT_UPDATE, i_sensor_address == 8'd0 && i_sensor_value == 8'd0)

    // Only defined verdict codes leave the block.
    `SFC_ASSERT_SAME(a_verdict_range, i_clk, i_rst_n, i_out_valid, i_verdict <= VERDICT_CHECKSUM)

endmodule

bind sensor_frame_checker_unit sfc_checker u_sfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_result.valid),
    .i_out_ready      (o_result.ready),
    .i_verdict        (o_result.verdict),
    .i_sensor_address (o_result.sensor_address),
    .i_sensor_value   (o_result.sensor_value),
    .i_flush_request  (o_result.flush_request)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

// Frame bytes are pushed into a queue by the stimulus process and sent one transfer at a
// time by the driver, in bursts with random gaps. Every accepted byte goes through a
// software copy of the frame checker. The verdict that the copy expects is compared with
// each verdict transfer that the block hands back. The receiver stalls on a pattern of
// its own. Registers change only between phases, once every pending verdict is in.
module testbench;
    import sfc_pkg::*;

    // This index is past the end of the register list, so a write to it must change nothing.
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int PHASE_COUNT = 6;
    localparam int PHASE_BYTES = 316;
    // A verdict passes the input and result registers before it leaves. The tail gives that some margin.
    localparam int DRAIN_CYCLES = 10;

    typedef logic [7:0] t_byte_q[$];

    // Running state of the frame that is being received.
    typedef struct {
        logic [2:0] byte_count;
        logic [7:0] start_byte;
        logic [7:0] addr_byte;
        logic [7:0] cmd_byte;
        logic [7:0] value_byte;
        logic [7:0] prev_byte;
        logic [7:0] xor_sum;
    } t_frame_state;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    sfc_in_if  frame_if ();
    sfc_out_if result_if ();

    sensor_frame_checker_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_frame     (frame_if),
        .o_result    (result_if)
    );

    always #5 i_clk = ~i_clk;

    // These are the frame bytes that wait to be sent, and the verdicts still owed by the block.
    t_item        byte_queue[$];
    t_result      verdict_queue[$];

    // The register values that the block should hold, and its frame state as the checker sees it.
    t_cfg         reg_copy = '0;
    t_frame_state frame_acc = '{default: '0};

    int           mismatches = 0;
    int           bytes_queued = 0;
    int           bytes_accepted = 0;
    int           verdicts_checked = 0;
    int           settings_used = 1;
    int           verdict_tally[6] = '{default: 0};

    int           burst_left = 0;
    int           gap_left = 0;
    t_item        next_byte;
    int           stall_mode = 0;
    int           mode_left = 0;
    int           stall_left = 0;
    t_result      want;

    // This task follows one accepted byte through the frame state. On the last byte of a frame
    // it works out the verdict, pushes it onto the list of owed verdicts and clears the state.
    // The checks run in priority order: length, start and end codes, address, checksum, and
    // then the command byte.
    task automatic judge_frame_byte(input logic [7:0] b, input logic last,
                                    input logic [7:0] exp_addr);
        logic [2:0] pos;
        t_result    r;
        pos = frame_acc.byte_count;
        case (pos)
            3'd0: frame_acc.start_byte = b;
            3'd1: frame_acc.addr_byte = b;
            3'd2: frame_acc.cmd_byte = b;
            3'd3: frame_acc.value_byte = b;
            default: ;
        endcase
        if (!last) begin
            // The running XOR lags one byte behind, so that the last two bytes stay out of it.
            if (pos != 3'd0) begin
                frame_acc.xor_sum = frame_acc.xor_sum ^ frame_acc.prev_byte;
            end
            frame_acc.prev_byte = b;
            if (frame_acc.byte_count != COUNT_MAX) begin
                frame_acc.byte_count = frame_acc.byte_count + 3'd1;
            end
        end else begin
            r = '0;
            if (int'(pos) + 1 < MIN_FRAME_BYTES) begin
                r.verdict = VERDICT_SHORT;
            end else if (frame_acc.start_byte != reg_copy.start_code
                         || b != reg_copy.end_code) begin
                r.verdict = VERDICT_FORMAT;
                r.flush_request = 1'b1;
            end else if (frame_acc.addr_byte != exp_addr) begin
                r.verdict = VERDICT_ADDRESS;
                r.flush_request = 1'b1;
            end else if (frame_acc.prev_byte != frame_acc.xor_sum) begin
                r.verdict = VERDICT_CHECKSUM;
            end else if (frame_acc.cmd_byte == reg_copy.data_command) begin
                r.verdict = VERDICT_UPDATE;
                r.sensor_address = frame_acc.addr_byte;
                r.sensor_value = frame_acc.value_byte;
            end else begin
                r.verdict = VERDICT_OTHER;
            end
            verdict_queue.push_back(r);
            frame_acc = '{default: '0};
        end
    endtask

    // This function builds a well-formed frame under the current register values: the start
    // code, the address, the command and the value, then random payload, the checksum and the
    // end code. In the shortest frames the command or value position falls on the checksum.
    function automatic t_byte_q build_frame(int length, logic [7:0] addr, logic [7:0] cmd,
                                            logic [7:0] val);
        t_byte_q    bytes;
        logic [7:0] sum;
        bytes.push_back(reg_copy.start_code);
        bytes.push_back(addr);
        for (int i = 2; i < length - 2; i++) begin
            bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (length > 4) begin
            bytes[2] = cmd;
        end
        if (length > 5) begin
            bytes[3] = val;
        end
        sum = '0;
        foreach (bytes[i]) begin
            sum = sum ^ bytes[i];
        end
        bytes.push_back(sum);
        bytes.push_back(reg_copy.end_code);
        return bytes;
    endfunction

    // The block only looks at the expected address on the last byte. The address on every
    // other byte is random.
    task automatic queue_frame(input t_byte_q bytes, input logic [7:0] exp_addr);
        t_item it;
        foreach (bytes[i]) begin
            it.rx_byte = bytes[i];
            it.frame_end = (i == bytes.size() - 1);
            it.expected_address = it.frame_end ? exp_addr : 8'($urandom_range(0, 255));
            byte_queue.push_back(it);
            bytes_queued++;
        end
    endtask

    // Nearly half of the frames are well formed, so that they get past the format, address and checksum
    // checks and reach the command decision. The other frames carry one fault each, or are
    // short, or are pure noise.
    task automatic queue_random_bytes(input int target);
        t_byte_q    bytes;
        int         stop_at;
        int         kind;
        int         pick;
        int         length;
        logic [7:0] addr;
        logic [7:0] cmd;
        stop_at = bytes_queued + target;
        while (bytes_queued < stop_at) begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                length = $urandom_range(MIN_FRAME_BYTES, MIN_FRAME_BYTES + 3);
            end else if (pick < 95) begin
                length = $urandom_range(MIN_FRAME_BYTES, 12);
            end else begin
                // In long frames the byte count saturates, but the checksum still covers all bytes before it.
                length = $urandom_range(13, 24);
            end
            addr = 8'($urandom_range(0, 255));
            cmd = $urandom_range(0, 1) ? reg_copy.data_command : 8'($urandom_range(0, 255));
            bytes = build_frame(length, addr, cmd, 8'($urandom_range(0, 255)));
            if (kind < 45) begin
                queue_frame(bytes, addr);
            end else if (kind < 53) begin
                bytes[0] = bytes[0] ^ 8'($urandom_range(1, 255));
                queue_frame(bytes, addr);
            end else if (kind < 61) begin
                bytes[length - 1] = bytes[length - 1] ^ 8'($urandom_range(1, 255));
                queue_frame(bytes, addr);
            end else if (kind < 69) begin
                queue_frame(bytes, addr ^ 8'($urandom_range(1, 255)));
            end else if (kind < 79) begin
                // Flipping any byte from the command to the checksum breaks only the checksum relation.
                pick = $urandom_range(2, length - 2);
                bytes[pick] = bytes[pick] ^ 8'($urandom_range(1, 255));
                queue_frame(bytes, addr);
            end else if (kind < 89) begin
                bytes.delete();
                repeat ($urandom_range(1, MIN_FRAME_BYTES - 1)) begin
                    bytes.push_back(8'($urandom_range(0, 255)));
                end
                queue_frame(bytes, 8'($urandom_range(0, 255)));
            end else begin
                bytes.delete();
                repeat ($urandom_range(1, 10)) begin
                    bytes.push_back(8'($urandom_range(0, 255)));
                end
                queue_frame(bytes, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // This task waits until every queued byte has been sent and every owed verdict has come
    // back. It samples on the falling edge, so that the driver's and the checker's updates at
    // the rising edge have settled.
    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (byte_queue.size() != 0 || frame_if.valid || verdict_queue.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_START_CODE:   reg_copy.start_code = data;
            CFG_END_CODE:     reg_copy.end_code = data;
            CFG_DATA_COMMAND: reg_copy.data_command = data;
            default: ;
        endcase
    endtask

    // This is the driver. After each transfer it takes the next byte from the queue, unless a
    // gap is running. At the end of each burst it draws a new burst length and a new gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_if.valid <= 1'b0;
        end else if (!frame_if.valid || frame_if.ready) begin
            if (gap_left != 0) begin
                frame_if.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (byte_queue.size() != 0) begin
                next_byte = byte_queue.pop_front();
                frame_if.valid <= 1'b1;
                frame_if.rx_byte <= next_byte.rx_byte;
                frame_if.frame_end <= next_byte.frame_end;
                frame_if.expected_address <= next_byte.expected_address;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                frame_if.valid <= 1'b0;
            end
        end
    end

    // The receiver switches now and then between three modes: always ready, scattered
    // random stalls, and occasional long stalls.
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(64, 256);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0) begin
            result_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (stall_mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= ($urandom_range(0, 99) >= 30);
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        result_if.ready <= 1'b0;
                        stall_left <= $urandom_range(1, 24);
                    end else begin
                        result_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // This is the monitor and scoreboard. The verdict transfer is checked first. The byte
    // transfer is folded in after it, so that a verdict can never be matched against a
    // byte that is accepted at the same edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (verdict_queue.size() == 0) begin
                    $error("verdict transfer with no frame pending: verdict %0d",
                           result_if.verdict);
                    mismatches++;
                end else begin
                    want = verdict_queue.pop_front();
                    verdicts_checked++;
                    verdict_tally[int'(want.verdict)]++;
                    if (result_if.verdict !== want.verdict) begin
                        $error("verdict: expected %0d (%s), got %0d", want.verdict,
                               want.verdict.name(), result_if.verdict);
                        mismatches++;
                    end
                    if (result_if.sensor_address !== want.sensor_address) begin
                        $error("sensor_address: expected 0x%02h, got 0x%02h",
                               want.sensor_address, result_if.sensor_address);
                        mismatches++;
                    end
                    if (result_if.sensor_value !== want.sensor_value) begin
                        $error("sensor_value: expected 0x%02h, got 0x%02h",
                               want.sensor_value, result_if.sensor_value);
                        mismatches++;
                    end
                    if (result_if.flush_request !== want.flush_request) begin
                        $error("flush_request: expected %0b, got %0b",
                               want.flush_request, result_if.flush_request);
                        mismatches++;
                    end
                end
            end
            if (frame_if.valid && frame_if.ready) begin
                bytes_accepted++;
                judge_frame_byte(frame_if.rx_byte, frame_if.frame_end,
                                 frame_if.expected_address);
            end
        end
    end

    initial begin
        t_byte_q bytes;
        int      phase;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_START_CODE;
        i_cfg_data = 8'h00;
        frame_if.valid = 1'b0;
        frame_if.rx_byte = 8'h00;
        frame_if.frame_end = 1'b0;
        frame_if.expected_address = 8'h00;
        result_if.ready = 1'b0;

        // The directed frames use the register values after reset, which are all zero. There
        // is a one-byte frame, an update with the address and value at all ones, a frame with
        // another command, a wrong end code, an address mismatch and a broken checksum.
        bytes = '{reg_copy.start_code};
        queue_frame(bytes, 8'h00);
        bytes = build_frame(6, 8'hFF, reg_copy.data_command, 8'hFF);
        queue_frame(bytes, 8'hFF);
        bytes = build_frame(MIN_FRAME_BYTES, 8'h00, ~reg_copy.data_command, 8'h00);
        queue_frame(bytes, 8'h00);
        bytes = build_frame(MIN_FRAME_BYTES, 8'h5A, reg_copy.data_command, 8'h00);
        bytes[bytes.size() - 1] = ~reg_copy.end_code;
        queue_frame(bytes, 8'h5A);
        bytes = build_frame(MIN_FRAME_BYTES, 8'h00, reg_copy.data_command, 8'h00);
        queue_frame(bytes, 8'hFF);
        bytes = build_frame(MIN_FRAME_BYTES, 8'hA5, reg_copy.data_command, 8'h00);
        bytes[bytes.size() - 2] = bytes[bytes.size() - 2] ^ 8'h01;
        queue_frame(bytes, 8'hA5);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_random_bytes(PHASE_BYTES - bytes_queued);
        for (phase = 1; phase < PHASE_COUNT; phase++) begin
            wait_idle();
            case (phase)
                1: begin
                    write_reg(CFG_START_CODE, 8'hFF);
                    write_reg(CFG_END_CODE, 8'hFF);
                    write_reg(CFG_DATA_COMMAND, 8'hFF);
                end
                2: begin
                    write_reg(CFG_START_CODE, 8'h00);
                    write_reg(CFG_END_CODE, 8'hFF);
                    write_reg(CFG_DATA_COMMAND, 8'h00);
                end
                default: begin
                    write_reg(CFG_START_CODE, 8'($urandom_range(0, 255)));
                    write_reg(CFG_END_CODE, 8'($urandom_range(0, 255)));
                    write_reg(CFG_DATA_COMMAND, 8'($urandom_range(0, 255)));
                end
            endcase
            // A write to the index past the list must leave all three registers as they are.
            if (phase % 2 == 1) begin
                write_reg(CFG_SPARE_INDEX, 8'($urandom_range(0, 255)));
            end
            settings_used++;
            queue_random_bytes(PHASE_BYTES);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frame bytes under %0d register settings and checked %0d verdicts.",
                 bytes_accepted, settings_used, verdicts_checked);
        $display("Verdicts: update %0d, other %0d, short %0d, format %0d, address %0d, csum %0d",
                 verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
                 verdict_tally[4], verdict_tally[5]);
        if (mismatches == 0 && verdict_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // This is the watchdog. It fires only if a handshake hangs, because the slowest correct
    // run ends far sooner.
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
